>>> hdl/iirbp_pkg.sv
`timescale 1ns / 1ps
// shared types, widths, coefficient reset values and rounding helpers
// for the fourth-order band-pass filter; no dependencies
package iirbp_pkg;

  localparam int ORDER          = 4;
  localparam int COEF_FRAC_BITS = 14;
  localparam int HIST_FRAC_BITS = 14;
  localparam int COEF_W         = 18;
  localparam int SAMPLE_W       = 16;
  localparam int HIST_W         = 32;
  localparam int IDX_W          = 3;
  localparam int PX_W           = COEF_W + SAMPLE_W;
  localparam int FB_W           = COEF_W + HIST_W;
  // four feedback products plus the scaled feedforward sum, with headroom
  localparam int ACC_W          = FB_W + 3;
  localparam int OUT_SHIFT      = COEF_FRAC_BITS + HIST_FRAC_BITS;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [HIST_W-1:0]   hist_t;
  typedef logic signed [PX_W-1:0]     px_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FEED_0 = 3'd0,
    REG_FEED_2 = 3'd1,
    REG_FEED_4 = 3'd2,
    REG_BACK_1 = 3'd3,
    REG_BACK_2 = 3'd4,
    REG_BACK_3 = 3'd5,
    REG_BACK_4 = 3'd6
  } reg_idx_e;

  typedef struct packed {
    coef_t feed_0;
    coef_t feed_2;
    coef_t feed_4;
    coef_t back_1;
    coef_t back_2;
    coef_t back_3;
    coef_t back_4;
  } coef_set_t;

  localparam coef_t RST_FEED_0 = coef_t'(6071);
  localparam coef_t RST_FEED_2 = coef_t'(-12142);
  localparam coef_t RST_FEED_4 = coef_t'(6071);
  localparam coef_t RST_BACK_1 = coef_t'(-25615);
  localparam coef_t RST_BACK_2 = coef_t'(7452);
  localparam coef_t RST_BACK_3 = coef_t'(-1185);
  localparam coef_t RST_BACK_4 = coef_t'(3064);

  localparam acc_t HALF_HIST = acc_t'(1) <<< (COEF_FRAC_BITS - 1);
  localparam acc_t HALF_OUT  = acc_t'(1) <<< (OUT_SHIFT - 1);

  // accumulator to history format, round half away from zero, saturate
  function automatic hist_t hist_round(input acc_t a);
    acc_t   neg_adj;
    acc_t   sum;
    acc_t   sh;
    logic   fits;
    hist_t  res;
    neg_adj = {{(ACC_W-1){1'b0}}, a[ACC_W-1]};
    sum     = a + HALF_HIST - neg_adj;
    sh      = sum >>> COEF_FRAC_BITS;
    fits    = (&sh[ACC_W-1:HIST_W-1]) || (~|sh[ACC_W-1:HIST_W-1]);
    if (fits) begin
      res = hist_t'(sh[HIST_W-1:0]);
    end else if (sh[ACC_W-1]) begin
      res = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return res;
  endfunction

  // accumulator to integer output sample, round half away from zero, saturate
  function automatic sample_t out_round(input acc_t a);
    acc_t    neg_adj;
    acc_t    sum;
    acc_t    sh;
    logic    fits;
    sample_t res;
    neg_adj = {{(ACC_W-1){1'b0}}, a[ACC_W-1]};
    sum     = a + HALF_OUT - neg_adj;
    sh      = sum >>> OUT_SHIFT;
    fits    = (&sh[ACC_W-1:SAMPLE_W-1]) || (~|sh[ACC_W-1:SAMPLE_W-1]);
    if (fits) begin
      res = sample_t'(sh[SAMPLE_W-1:0]);
    end else if (sh[ACC_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> hdl/iirbp_coef.sv
`timescale 1ns / 1ps
// coefficient register file with its write port
// depends on iirbp_pkg
module iirbp_coef (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [iirbp_pkg::IDX_W-1:0] cfg_index_i,
  input  iirbp_pkg::coef_t            cfg_data_i,
  output logic                        cfg_ready_o,
  output iirbp_pkg::coef_set_t        coef_o
);
  import iirbp_pkg::*;

  coef_set_t coef_q, coef_d;
  logic      wr_en;

  // registers accept a write in every cycle
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_comb begin
    coef_d = coef_q;
    if (wr_en) begin
      unique case (cfg_index_i)
        REG_FEED_0: coef_d.feed_0 = cfg_data_i;
        REG_FEED_2: coef_d.feed_2 = cfg_data_i;
        REG_FEED_4: coef_d.feed_4 = cfg_data_i;
        REG_BACK_1: coef_d.back_1 = cfg_data_i;
        REG_BACK_2: coef_d.back_2 = cfg_data_i;
        REG_BACK_3: coef_d.back_3 = cfg_data_i;
        REG_BACK_4: coef_d.back_4 = cfg_data_i;
        default:    coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.feed_0 <= RST_FEED_0;
      coef_q.feed_2 <= RST_FEED_2;
      coef_q.feed_4 <= RST_FEED_4;
      coef_q.back_1 <= RST_BACK_1;
      coef_q.back_2 <= RST_BACK_2;
      coef_q.back_3 <= RST_BACK_3;
      coef_q.back_4 <= RST_BACK_4;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> hdl/iirbp_cell.sv
`timescale 1ns / 1ps
// one history cell of the direct form I chain: holds one past input and one
// past output, shifts both to its neighbor and forms its weighted term; depends on iirbp_pkg
module iirbp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  iirbp_pkg::sample_t x_i,
  input  iirbp_pkg::hist_t   y_i,
  input  iirbp_pkg::coef_t   feed_i,
  input  iirbp_pkg::coef_t   back_i,
  output iirbp_pkg::sample_t x_o,
  output iirbp_pkg::hist_t   y_o,
  output iirbp_pkg::acc_t    term_o
);
  import iirbp_pkg::*;

  sample_t                x_q;
  hist_t                  y_q;
  px_t                    ff_prod;
  logic signed [FB_W-1:0] fb_prod;

  assign ff_prod = feed_i * x_q;
  assign fb_prod = back_i * y_q;

  // feedforward term scaled to history fraction bits, feedback subtracted
  assign term_o = (acc_t'(ff_prod) <<< HIST_FRAC_BITS) - acc_t'(fb_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (en_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

>>> hdl/iir_bandpass_fourth_order.sv
`timescale 1ns / 1ps
// fourth-order band-pass filter, direct form I chain of four history cells
// the input sample is registered in the input stage, the result in the output register
// throughput: one sample per cycle while the output is not stalled, set by the
//   feedback loop from the output history through the seven products, the adder
//   tree and rounding back into the first cell
// reset: clears input and output history and loads default coefficients
module iir_bandpass_fourth_order (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  iirbp_pkg::sample_t          sample_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output iirbp_pkg::sample_t          sample_out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [iirbp_pkg::IDX_W-1:0] cfg_index_i,
  input  iirbp_pkg::coef_t            cfg_data_i
);
  import iirbp_pkg::*;

  coef_set_t coef;
  logic      in_fire, step_fire;
  logic      pre_valid_q, pre_valid_d;
  logic      out_valid_q, out_valid_d;
  sample_t   x_pre_q;
  px_t       px0;
  sample_t   sample_out_q;
  acc_t      acc;
  hist_t     y_new;
  sample_t   x_arr [ORDER];
  hist_t     y_arr [ORDER];
  acc_t      term_arr [ORDER];
  coef_t     coef_feed [ORDER];
  coef_t     coef_back [ORDER];

  iirbp_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .coef_o      (coef)
  );

  // input stage feeding the chain, output register behind it
  assign step_fire  = pre_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pre_valid_q && !step_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    pre_valid_d = pre_valid_q;
    if (in_fire) begin
      pre_valid_d = 1'b1;
    end else if (step_fire) begin
      pre_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pre_valid_q <= pre_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_pre_q <= sample_in_i;
    end
    if (step_fire) begin
      sample_out_q <= out_round(acc);
    end
  end

  assign px0   = coef.feed_0 * x_pre_q;
  assign acc   = ((acc_t'(px0) <<< HIST_FRAC_BITS) + term_arr[0])
               + (term_arr[1] + term_arr[2]) + term_arr[3];
  assign y_new = hist_round(acc);

  // odd feedforward taps are fixed at zero
  assign coef_feed[0] = '0;
  assign coef_feed[1] = coef.feed_2;
  assign coef_feed[2] = '0;
  assign coef_feed[3] = coef.feed_4;
  assign coef_back[0] = coef.back_1;
  assign coef_back[1] = coef.back_2;
  assign coef_back[2] = coef.back_3;
  assign coef_back[3] = coef.back_4;

  for (genvar k = 0; k < ORDER; k++) begin : g_tap
    sample_t x_prev;
    hist_t   y_prev;
    if (k == 0) begin : g_first
      assign x_prev = x_pre_q;
      assign y_prev = y_new;
    end else begin : g_rest
      assign x_prev = x_arr[k-1];
      assign y_prev = y_arr[k-1];
    end
    iirbp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (step_fire),
      .x_i    (x_prev),
      .y_i    (y_prev),
      .feed_i (coef_feed[k]),
      .back_i (coef_back[k]),
      .x_o    (x_arr[k]),
      .y_o    (y_arr[k]),
      .term_o (term_arr[k])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pre_valid_q)
    else $error("input stalled with empty input stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pre_valid_q)
    else $error("accepted transaction lost before the chain");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> out_valid_q)
    else $error("chain step without output result");

  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(x_arr[ORDER-1]) && $stable(y_arr[ORDER-1]))
    else $error("history moved without a transaction");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the fourth-order band-pass filter: random sample traffic
// with stalls on both sides, coefficient reprogramming between phases, bit-exact predictor
// depends on hdl/iirbp_pkg.sv and hdl/iir_bandpass_fourth_order.sv
module tb;
  import iirbp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;
  localparam coef_set_t DEFAULT_COEFS = '{RST_FEED_0, RST_FEED_2, RST_FEED_4,
                                          RST_BACK_1, RST_BACK_2, RST_BACK_3, RST_BACK_4};

  logic             clk_i;
  logic             rst_ni     = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  sample_t          sample_in  = '0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  sample_t          sample_out;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index  = '0;
  coef_t            cfg_data   = '0;

  // predictor state
  coef_set_t coefs = DEFAULT_COEFS;
  sample_t   x_hist [ORDER] = '{default: '0};
  hist_t     y_hist [ORDER] = '{default: '0};

  sample_t sample_backlog[$];
  sample_t predicted_samples[$];
  sample_t oldest_sample;
  int      src_gap_pct    = 0;
  int      sink_stall_pct = 0;
  int      src_hold       = 0;
  int      sink_hold      = 0;
  int      mismatch_count = 0;
  int      cycle_count;

  iir_bandpass_fourth_order dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // divide by 2^s, halves away from zero
  function automatic longint round_away(input longint v, input int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic sample_t predict_sample(input sample_t x);
    longint feed;
    longint back;
    longint acc;
    longint y_new;
    longint y_out;
    feed = longint'(coefs.feed_0) * longint'(x)
         + longint'(coefs.feed_2) * longint'(x_hist[1])
         + longint'(coefs.feed_4) * longint'(x_hist[3]);
    back = longint'(coefs.back_1) * longint'(y_hist[0])
         + longint'(coefs.back_2) * longint'(y_hist[1])
         + longint'(coefs.back_3) * longint'(y_hist[2])
         + longint'(coefs.back_4) * longint'(y_hist[3]);
    acc   = feed * (longint'(1) <<< HIST_FRAC_BITS) - back;
    y_new = clamp(round_away(acc, COEF_FRAC_BITS),
                  -(longint'(1) <<< (HIST_W - 1)), (longint'(1) <<< (HIST_W - 1)) - 1);
    y_out = clamp(round_away(acc, OUT_SHIFT), -32768, 32767);
    for (int i = ORDER - 1; i > 0; i--) begin
      x_hist[i] = x_hist[i-1];
      y_hist[i] = y_hist[i-1];
    end
    x_hist[0] = x;
    y_hist[0] = hist_t'(y_new);
    return sample_t'(y_out);
  endfunction

  // input driver: holds a stalled transaction, inserts idle bursts between items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predicted_samples.push_back(predict_sample(sample_in));
      end
      if (!in_valid || !in_stall) begin
        if (src_hold > 0) begin
          in_valid <= 1'b0;
          src_hold <= src_hold - 1;
        end else if (sample_backlog.size() > 0 && $urandom_range(0, 99) < src_gap_pct) begin
          in_valid <= 1'b0;
          src_hold <= $urandom_range(0, 14);
        end else if (sample_backlog.size() > 0) begin
          in_valid  <= 1'b1;
          sample_in <= sample_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (predicted_samples.size() == 0) begin
          report_mismatch($sformatf("output sample %0d with nothing predicted", sample_out));
        end else begin
          oldest_sample = predicted_samples.pop_front();
          if (sample_out !== oldest_sample) begin
            report_mismatch($sformatf("sample_out got %0d want %0d", sample_out, oldest_sample));
          end
        end
      end
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        sink_hold <= sink_hold - 1;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        out_stall <= 1'b1;
        sink_hold <= $urandom_range(0, 14);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a rising edge; leaves cfg_valid high for a back-to-back transaction
  task automatic write_coef(input logic [IDX_W-1:0] idx, input coef_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_FEED_0: coefs.feed_0 = val;
      REG_FEED_2: coefs.feed_2 = val;
      REG_FEED_4: coefs.feed_4 = val;
      REG_BACK_1: coefs.back_1 = val;
      REG_BACK_2: coefs.back_2 = val;
      REG_BACK_3: coefs.back_3 = val;
      REG_BACK_4: coefs.back_4 = val;
      default: ;
    endcase
  endtask

  task automatic program_coefs(input coef_set_t c, input bit poke_unused);
    @(posedge clk_i);
    write_coef(REG_FEED_0, c.feed_0);
    write_coef(REG_FEED_2, c.feed_2);
    write_coef(REG_FEED_4, c.feed_4);
    write_coef(REG_BACK_1, c.back_1);
    write_coef(REG_BACK_2, c.back_2);
    write_coef(REG_BACK_3, c.back_3);
    write_coef(REG_BACK_4, c.back_4);
    // out-of-range index must leave every coefficient alone
    if (poke_unused) write_coef(IDX_UNUSED, coef_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (sample_backlog.size() != 0 || in_valid || predicted_samples.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic coef_t rand_coef(input int bits);
    if (bits >= COEF_W) return coef_t'($urandom);
    return coef_t'(int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  task automatic run_batch(input int n, input int gap_pct, input int stall_pct);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        sample_backlog.push_back(sample_t'($urandom));
      end else if (pick < 8) begin
        sample_backlog.push_back(sample_t'(int'($urandom_range(0, 511)) - 256));
      end else if (pick == 8) begin
        sample_backlog.push_back($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      end else begin
        sample_backlog.push_back($urandom_range(0, 1) ? 16'sh0000 : 16'shffff);
      end
    end
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    wait_drained();
  endtask

  initial begin
    coef_set_t c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default coefficients straight out of reset
    src_gap_pct    = 25;
    sink_stall_pct = 25;
    sample_backlog = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
                       16'sh7fff, 16'sh7fff, 16'sh8000};
    wait_drained();
    run_batch(200, 25, 25);

    // extreme feedforward gains: output and history both saturate
    c = '{coef_t'(131071), coef_t'(-131072), coef_t'(131071), '0, '0, '0, '0};
    program_coefs(c, 1'b0);
    sample_backlog = '{16'sh7fff, 16'sh8000, 16'sh1000, -16'sd4097, 16'sh0000};
    wait_drained();
    run_batch(100, 10, 40);

    // tiny feedforward and half-weight feedback so exact halves show up
    c = '{coef_t'(1), '0, '0, coef_t'(8192), '0, '0, '0};
    program_coefs(c, 1'b1);
    sample_backlog = '{16'sd8192, -16'sd8192, 16'sd24576, -16'sd24576};
    wait_drained();
    run_batch(100, 40, 10);

    // runaway feedback with extreme coefficients
    c = '{coef_t'(16384), '0, '0, coef_t'(-131072), '0, '0, coef_t'(131071)};
    program_coefs(c, 1'b0);
    sample_backlog = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
    wait_drained();
    run_batch(100, 0, 0);

    for (int k = 0; k < 7; k++) begin
      case (k % 3)
        0: c = '{rand_coef(COEF_W), rand_coef(COEF_W), rand_coef(COEF_W),
                 rand_coef(12), rand_coef(12), rand_coef(10), rand_coef(10)};
        1: c = '{rand_coef(COEF_W), rand_coef(COEF_W), rand_coef(COEF_W),
                 rand_coef(COEF_W), rand_coef(COEF_W), rand_coef(COEF_W), rand_coef(COEF_W)};
        default: c = DEFAULT_COEFS;
      endcase
      program_coefs(c, k == 1);
      run_batch(150, (k * 17) % 45, (k * 29 + 10) % 50);
    end

    // closing stretch with no idling on either side
    program_coefs(DEFAULT_COEFS, 1'b0);
    run_batch(150, 0, 0);

    repeat (4) @(posedge clk_i);
    if (predicted_samples.size() != 0) begin
      report_mismatch($sformatf("%0d predicted samples never arrived", predicted_samples.size()));
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

endmodule
